FILE: design/mesh_outline_edge_finder_assert.svh
// Assertion macros for the mesh outline edge finder.
// Used by design/mesh_outline_edge_finder.sv; expects i_clk and i_rst_n in scope.
`ifndef MESH_OUTLINE_EDGE_FINDER_ASSERT_SVH
`define MESH_OUTLINE_EDGE_FINDER_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define MOFE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MOFE_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/mofe_pkg.sv
// Shared constants for the mesh outline edge finder: field widths, command
// and status codes, and parameter defaults. No dependencies.
package mofe_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_CORNERS_DEF  = 3072;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 32;
    localparam int VIDX_W  = 16;
    localparam int COUNT_W = 12;
    localparam int STAT_W  = 2;
    localparam int MD_W    = 16;

    localparam logic [MD_W-1:0] MERGE_DIST_RESET = 16'd7;

    localparam logic [CMD_W-1:0] CMD_LOAD_VERTEX = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_INDEX  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

endpackage

FILE: design/mesh_outline_edge_finder.sv
// Load items (vertex or corner) are taken one per cycle while the block is idle. A fetch
// item reads the outline store, then the corner store, then waits for the output register
// (with no edge left it goes straight to that wait). Compute runs over stored data with
// ready low: it runs a key fill over the vertices, a vertex merge sort (read and compare
// steps per element per pass, plus group setup), a weld walk over the vertices, an edge
// build over the whole triangles of the loaded corners (a check, then corner read, weld
// read and write per side), an edge merge sort and an outline scan over the edges kept
// after dropping bad and degenerate ones. The one shared merge comparator sets the pace,
// as each sort step waits on a registered read of the ping-pong sort memories. A compute
// or fetch result also holds the sequencer while the output register is full. Stores
// power up undefined and need no clearing pass.
// Depends on mofe_pkg and mesh_outline_edge_finder_assert.svh.
`include "mesh_outline_edge_finder_assert.svh"

module mesh_outline_edge_finder #(
    parameter int MAX_VERTICES = mofe_pkg::MAX_VERTICES_DEF,
    parameter int MAX_CORNERS  = mofe_pkg::MAX_CORNERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,       // merge_distance
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [111:0] i_s_axis_tdata,    // pos_x, pos_y, pos_z, vertex_index
    input  logic [2:0]   i_s_axis_tuser,    // command
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [47:0]  o_m_axis_tdata,    // edge_from, edge_to, edge_count, 4 zero bits
    output logic         o_m_axis_tlast,    // is_last
    output logic [1:0]   o_m_axis_tuser     // status
);

    localparam int PW   = mofe_pkg::POS_W;
    localparam int OCW  = mofe_pkg::COUNT_W;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int CAW  = $clog2(MAX_CORNERS);
    localparam int CCW  = $clog2(MAX_CORNERS + 1);
    localparam int DEP  = (MAX_VERTICES > MAX_CORNERS) ? MAX_VERTICES : MAX_CORNERS;
    localparam int AW   = $clog2(DEP);
    localparam int NW   = $clog2(DEP + 1);
    localparam int WW   = NW + 1;
    localparam int VKW  = 3 * PW + VW;
    localparam int EKW  = 2 * VW + 2 * CAW;
    localparam int SKW  = (VKW > EKW) ? VKW : EKW;
    localparam int CMPW = (VCW > mofe_pkg::VIDX_W) ? VCW : mofe_pkg::VIDX_W;
    localparam int TW   = CCW + 2;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_FV_RD   = 5'd1;
    localparam logic [4:0] S_FV_WR   = 5'd2;
    localparam logic [4:0] S_SRT_INI = 5'd3;
    localparam logic [4:0] S_SRT_PAS = 5'd4;
    localparam logic [4:0] S_SRT_GRP = 5'd5;
    localparam logic [4:0] S_SRT_GR2 = 5'd6;
    localparam logic [4:0] S_SRT_RD  = 5'd7;
    localparam logic [4:0] S_SRT_CMP = 5'd8;
    localparam logic [4:0] S_WL_RD   = 5'd9;
    localparam logic [4:0] S_WL_WR   = 5'd10;
    localparam logic [4:0] S_ED_CHK  = 5'd11;
    localparam logic [4:0] S_ED_RDC  = 5'd12;
    localparam logic [4:0] S_ED_RDW  = 5'd13;
    localparam logic [4:0] S_ED_WR   = 5'd14;
    localparam logic [4:0] S_SC_RD   = 5'd15;
    localparam logic [4:0] S_SC_CHK  = 5'd16;
    localparam logic [4:0] S_SC_END  = 5'd17;
    localparam logic [4:0] S_F_RDO   = 5'd18;
    localparam logic [4:0] S_F_RDC   = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    localparam logic [1:0] RK_COMP  = 2'd0;
    localparam logic [1:0] RK_FOK   = 2'd1;
    localparam logic [1:0] RK_FNONE = 2'd2;

    // control and counts
    logic [4:0]          r_state;
    logic [15:0]         r_md;
    logic [VCW-1:0]      r_vt;
    logic [CCW-1:0]      r_ct, r_ot, r_fp, r_ne;
    logic                r_ovf;
    logic [NW-1:0]       r_n, r_lo, r_mid, r_hi, r_p, r_q, r_k, r_i;
    logic [WW-1:0]       r_w;
    logic                r_kind, r_src;
    logic [CCW-1:0]      r_t;
    logic [1:0]          r_kk;
    logic                r_ev, r_multi;
    logic [VW-1:0]       r_rep;
    logic [PW-1:0]       r_rx, r_ry, r_rz;
    logic [SKW-1:0]      r_prev;
    logic [1:0]          r_rk;
    logic                r_ov, r_olast;
    logic [15:0]         r_ofrom, r_oto;
    logic [OCW-1:0]      r_ocnt;
    logic [1:0]          r_ostat;

    // memories and their registered read data
    logic [3*PW-1:0]     pos_mem [MAX_VERTICES];
    logic [15:0]         cor_mem [MAX_CORNERS];
    logic [VW-1:0]       weld_mem [MAX_VERTICES];
    logic [SKW-1:0]      buf0_mem [DEP];
    logic [SKW-1:0]      buf1_mem [DEP];
    logic [2*CAW-1:0]    ol_mem [MAX_CORNERS];
    logic [3*PW-1:0]     r_pos_rd;
    logic [15:0]         r_cr0, r_cr1;
    logic [VW-1:0]       r_wr0, r_wr1;
    logic [SKW-1:0]      r_b0a, r_b0b, r_b1a, r_b1b;
    logic [2*CAW-1:0]    r_ol;

    // handshake and input fields
    logic                s_acc;
    logic                out_load;
    logic [2:0]          cmd;
    logic [PW-1:0]       in_x, in_y, in_z;
    logic [15:0]         in_vidx;
    logic                vt_room, ct_room;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_OUT) && (!r_ov || i_m_axis_tready);
    assign cmd     = i_s_axis_tuser;
    assign in_x    = i_s_axis_tdata[31:0];
    assign in_y    = i_s_axis_tdata[63:32];
    assign in_z    = i_s_axis_tdata[95:64];
    assign in_vidx = i_s_axis_tdata[111:96];
    assign vt_room = (r_vt < VCW'(MAX_VERTICES));
    assign ct_room = (r_ct < CCW'(MAX_CORNERS));

    // memory port control
    logic                pos_we, cor_we, cor_re, weld_we, weld_re, buf_we, buf_wsel;
    logic                ol_we, ol_re;
    logic [CAW-1:0]      cor_ra0, cor_ra1, e_ta, e_tn;
    logic [AW-1:0]       buf_wa, buf_ra0, buf_ra1;
    logic [SKW-1:0]      buf_wd;
    logic [VW-1:0]       weld_wa, weld_wd;
    logic [SKW-1:0]      key_a, key_b;
    logic                b_lt_a, take_p;
    logic [VW-1:0]       v_idx, e_lo, e_hi;
    logic [PW-1:0]       v_x, v_y, v_z;
    logic                far_x, far_y, far_z, v_new;
    logic                pair_eq, ed_ok;
    logic [TW-1:0]       t_end;

    function automatic logic too_far(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                     input logic [15:0] md);
        logic [PW-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d > PW'(md);
    endfunction

    assign key_a  = r_src ? r_b1a : r_b0a;
    assign key_b  = r_src ? r_b1b : r_b0b;
    assign b_lt_a = key_b < key_a;
    assign take_p = (r_p < r_mid) && ((r_q >= r_hi) || !b_lt_a);

    assign v_x    = key_a[VKW-1 -: PW];
    assign v_y    = key_a[VKW-PW-1 -: PW];
    assign v_z    = key_a[VKW-2*PW-1 -: PW];
    assign v_idx  = key_a[VW-1:0];
    assign far_x  = too_far(v_x, r_rx, r_md);
    assign far_y  = too_far(v_y, r_ry, r_md);
    assign far_z  = too_far(v_z, r_rz, r_md);
    assign v_new  = (r_i == '0) || far_x || far_y || far_z;

    assign e_ta   = CAW'(r_t + CCW'(r_kk));
    assign e_tn   = (r_kk == 2'd2) ? CAW'(r_t) : CAW'(r_t + CCW'(r_kk) + CCW'(1));
    assign e_lo   = (r_wr0 < r_wr1) ? r_wr0 : r_wr1;
    assign e_hi   = (r_wr0 < r_wr1) ? r_wr1 : r_wr0;
    assign ed_ok  = (CMPW'(r_cr0) < CMPW'(r_vt)) && (CMPW'(r_cr1) < CMPW'(r_vt));
    assign t_end  = TW'(r_t) + TW'(3);
    assign pair_eq = (key_a[EKW-1:2*CAW] == r_prev[EKW-1:2*CAW]);

    always_comb begin
        pos_we   = s_acc && (cmd == mofe_pkg::CMD_LOAD_VERTEX) && vt_room;
        cor_we   = s_acc && (cmd == mofe_pkg::CMD_LOAD_INDEX) && ct_room;
        cor_re   = 1'b0;
        cor_ra0  = e_ta;
        cor_ra1  = e_tn;
        weld_re  = (r_state == S_ED_RDW);
        weld_we  = (r_state == S_WL_WR);
        weld_wa  = v_idx;
        weld_wd  = v_new ? v_idx : r_rep;
        buf_we   = 1'b0;
        buf_wsel = 1'b0;
        buf_wa   = r_i[AW-1:0];
        buf_wd   = SKW'({r_pos_rd, r_i[VW-1:0]});
        buf_ra0  = (r_state == S_SRT_RD) ? r_p[AW-1:0] : r_i[AW-1:0];
        buf_ra1  = r_q[AW-1:0];
        ol_we    = 1'b0;
        ol_re    = (r_state == S_F_RDO);
        case (r_state)
            S_FV_WR: begin
                buf_we = 1'b1;
            end
            S_ED_RDC: begin
                cor_re = 1'b1;
            end
            S_ED_WR: begin
                buf_we = r_ev && (r_wr0 != r_wr1);
                buf_wa = AW'(r_ne);
                buf_wd = SKW'({e_lo, e_hi, e_ta, e_tn});
            end
            S_SRT_CMP: begin
                buf_we   = 1'b1;
                buf_wsel = ~r_src;
                buf_wa   = r_k[AW-1:0];
                buf_wd   = take_p ? key_a : key_b;
            end
            S_SC_CHK: begin
                ol_we = (r_i != '0) && !pair_eq && !r_multi;
            end
            S_SC_END: begin
                ol_we = (r_ne != '0) && !r_multi;
            end
            S_F_RDC: begin
                cor_re  = 1'b1;
                cor_ra0 = r_ol[2*CAW-1:CAW];
                cor_ra1 = r_ol[CAW-1:0];
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[r_vt[VW-1:0]] <= {~in_x[PW-1], in_x[PW-2:0], ~in_y[PW-1], in_y[PW-2:0],
                                      ~in_z[PW-1], in_z[PW-2:0]};
        end
        r_pos_rd <= pos_mem[r_i[VW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cor_we) begin
            cor_mem[r_ct[CAW-1:0]] <= in_vidx;
        end
        if (cor_re) begin
            r_cr0 <= cor_mem[cor_ra0];
            r_cr1 <= cor_mem[cor_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (weld_we) begin
            weld_mem[weld_wa] <= weld_wd;
        end
        if (weld_re) begin
            r_wr0 <= weld_mem[r_cr0[VW-1:0]];
            r_wr1 <= weld_mem[r_cr1[VW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we && !buf_wsel) begin
            buf0_mem[buf_wa] <= buf_wd;
        end
        r_b0a <= buf0_mem[buf_ra0];
        r_b0b <= buf0_mem[buf_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we && buf_wsel) begin
            buf1_mem[buf_wa] <= buf_wd;
        end
        r_b1a <= buf1_mem[buf_ra0];
        r_b1b <= buf1_mem[buf_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (ol_we) begin
            ol_mem[r_ot[CAW-1:0]] <= r_prev[2*CAW-1:0];
        end
        if (ol_re) begin
            r_ol <= ol_mem[r_fp[CAW-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_md    <= mofe_pkg::MERGE_DIST_RESET;
            r_vt    <= '0;
            r_ct    <= '0;
            r_ot    <= '0;
            r_fp    <= '0;
            r_ne    <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
            r_kind  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_md <= i_cfg_wdata;
            end
            // drop the taken result unless a new one loads at the same edge
            if (r_ov && i_m_axis_tready && !out_load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        case (cmd)
                            mofe_pkg::CMD_LOAD_VERTEX: begin
                                if (vt_room) r_vt <= r_vt + VCW'(1);
                                else r_ovf <= 1'b1;
                            end
                            mofe_pkg::CMD_LOAD_INDEX: begin
                                if (ct_room) r_ct <= r_ct + CCW'(1);
                                else r_ovf <= 1'b1;
                            end
                            mofe_pkg::CMD_COMPUTE: begin
                                r_i     <= '0;
                                r_src   <= 1'b0;
                                r_ot    <= '0;
                                r_fp    <= '0;
                                r_state <= S_FV_RD;
                            end
                            mofe_pkg::CMD_FETCH: begin
                                if (r_fp < r_ot) begin
                                    r_state <= S_F_RDO;
                                end else begin
                                    r_rk    <= RK_FNONE;
                                    r_state <= S_OUT;
                                end
                            end
                            mofe_pkg::CMD_CLEAR: begin
                                r_vt  <= '0;
                                r_ct  <= '0;
                                r_ot  <= '0;
                                r_fp  <= '0;
                                r_ovf <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // build sort keys from the position store
                S_FV_RD: begin
                    if (r_i < NW'(r_vt)) begin
                        r_state <= S_FV_WR;
                    end else begin
                        r_n     <= NW'(r_vt);
                        r_kind  <= 1'b0;
                        r_state <= S_SRT_INI;
                    end
                end
                S_FV_WR: begin
                    r_i     <= r_i + NW'(1);
                    r_state <= S_FV_RD;
                end
                // bottom-up merge sort, ping-pong between the two buffers
                S_SRT_INI: begin
                    r_w     <= WW'(1);
                    r_state <= S_SRT_PAS;
                end
                S_SRT_PAS: begin
                    if (r_w < WW'(r_n)) begin
                        r_lo    <= '0;
                        r_state <= S_SRT_GRP;
                    end else begin
                        r_i     <= '0;
                        r_state <= r_kind ? S_SC_RD : S_WL_RD;
                    end
                end
                S_SRT_GRP: begin
                    r_mid   <= (WW'(r_n - r_lo) > r_w) ? NW'(WW'(r_lo) + r_w) : r_n;
                    r_state <= S_SRT_GR2;
                end
                S_SRT_GR2: begin
                    r_hi    <= (WW'(r_n - r_mid) > r_w) ? NW'(WW'(r_mid) + r_w) : r_n;
                    r_p     <= r_lo;
                    r_q     <= r_mid;
                    r_k     <= r_lo;
                    r_state <= S_SRT_RD;
                end
                S_SRT_RD: begin
                    if ((r_p < r_mid) || (r_q < r_hi)) begin
                        r_state <= S_SRT_CMP;
                    end else if (r_hi >= r_n) begin
                        r_src   <= ~r_src;
                        r_w     <= r_w << 1;
                        r_state <= S_SRT_PAS;
                    end else begin
                        r_lo    <= r_hi;
                        r_state <= S_SRT_GRP;
                    end
                end
                S_SRT_CMP: begin
                    if (take_p) r_p <= r_p + NW'(1);
                    else r_q <= r_q + NW'(1);
                    r_k     <= r_k + NW'(1);
                    r_state <= S_SRT_RD;
                end
                // weld walk in sorted order
                S_WL_RD: begin
                    if (r_i < NW'(r_vt)) begin
                        r_state <= S_WL_WR;
                    end else begin
                        r_t     <= '0;
                        r_kk    <= 2'd0;
                        r_ne    <= '0;
                        r_src   <= 1'b0;
                        r_state <= S_ED_CHK;
                    end
                end
                S_WL_WR: begin
                    if (v_new) begin
                        r_rep <= v_idx;
                        r_rx  <= v_x;
                        r_ry  <= v_y;
                        r_rz  <= v_z;
                    end
                    r_i     <= r_i + NW'(1);
                    r_state <= S_WL_RD;
                end
                // triangle sides through the weld map
                S_ED_CHK: begin
                    if (t_end <= TW'(r_ct)) begin
                        r_state <= S_ED_RDC;
                    end else begin
                        r_n     <= NW'(r_ne);
                        r_kind  <= 1'b1;
                        r_state <= S_SRT_INI;
                    end
                end
                S_ED_RDC: begin
                    r_state <= S_ED_RDW;
                end
                S_ED_RDW: begin
                    r_ev    <= ed_ok;
                    r_state <= S_ED_WR;
                end
                S_ED_WR: begin
                    if (r_ev && (r_wr0 != r_wr1)) begin
                        r_ne <= r_ne + CCW'(1);
                    end
                    if (r_kk == 2'd2) begin
                        r_kk    <= 2'd0;
                        r_t     <= r_t + CCW'(3);
                        r_state <= S_ED_CHK;
                    end else begin
                        r_kk    <= r_kk + 2'd1;
                        r_state <= S_ED_RDC;
                    end
                end
                // keep pairs that occur once
                S_SC_RD: begin
                    r_state <= (r_i < NW'(r_ne)) ? S_SC_CHK : S_SC_END;
                end
                S_SC_CHK: begin
                    if (r_i == '0) begin
                        r_prev  <= key_a;
                        r_multi <= 1'b0;
                    end else if (pair_eq) begin
                        r_multi <= 1'b1;
                    end else begin
                        if (!r_multi) r_ot <= r_ot + CCW'(1);
                        r_prev  <= key_a;
                        r_multi <= 1'b0;
                    end
                    r_i     <= r_i + NW'(1);
                    r_state <= S_SC_RD;
                end
                S_SC_END: begin
                    if ((r_ne != '0) && !r_multi) begin
                        r_ot <= r_ot + CCW'(1);
                    end
                    r_fp    <= '0;
                    r_rk    <= RK_COMP;
                    r_state <= S_OUT;
                end
                S_F_RDO: begin
                    r_state <= S_F_RDC;
                end
                S_F_RDC: begin
                    r_rk    <= RK_FOK;
                    r_state <= S_OUT;
                end
                // hold until the output register is free
                S_OUT: begin
                    if (out_load) begin
                        r_ov <= 1'b1;
                        case (r_rk)
                            RK_COMP: begin
                                r_ofrom <= '0;
                                r_oto   <= '0;
                                r_ocnt  <= OCW'(r_ot);
                                r_olast <= 1'b0;
                                r_ostat <= r_ovf ? mofe_pkg::STAT_OVERFLOW : mofe_pkg::STAT_OK;
                            end
                            RK_FOK: begin
                                r_ofrom <= r_cr0;
                                r_oto   <= r_cr1;
                                r_ocnt  <= '0;
                                r_olast <= ((r_fp + CCW'(1)) == r_ot);
                                r_ostat <= mofe_pkg::STAT_OK;
                                r_fp    <= r_fp + CCW'(1);
                            end
                            default: begin
                                r_ofrom <= '0;
                                r_oto   <= '0;
                                r_ocnt  <= '0;
                                r_olast <= 1'b0;
                                r_ostat <= mofe_pkg::STAT_EMPTY;
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'b0000, r_ocnt, r_oto, r_ofrom};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ostat;

    `MOFE_ASSERT_RST(a_fp_in_range, r_fp <= r_ot, "fetch pointer passed the outline total")
    `MOFE_ASSERT_RST(a_vt_in_range, r_vt <= VCW'(MAX_VERTICES), "vertex count over capacity")
    `MOFE_ASSERT_RST(a_last_is_ok, r_ov && r_olast |-> r_ostat == mofe_pkg::STAT_OK, "bad last")
    `MOFE_ASSERT_RST(a_compute_busy, s_acc && cmd == mofe_pkg::CMD_COMPUTE |=> r_state != S_IDLE, "compute did not start")

endmodule
